// ===== sv/ssfm_pkg.sv =====
// ----------------------------------------------------------------------------
// ssfm_pkg
// Shared types and codes of the SPI slave mailbox with transmit/receive rings.
// ----------------------------------------------------------------------------
package ssfm_pkg;

    localparam int RING_DEPTH_DEF = 32;

    // Request command codes
    localparam logic [1:0] CMD_SPI  = 2'd0;
    localparam logic [1:0] CMD_PUSH = 2'd1;
    localparam logic [1:0] CMD_POP  = 2'd2;

    // Bytes from the master while the protocol is idle
    localparam logic [7:0] SPI_POLL = 8'h00;
    localparam logic [7:0] SPI_SEND = 8'h01;
    localparam logic [7:0] SPI_RECV = 8'h02;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_SEND = 2'd1,
        MODE_RECV = 2'd2
    } mode_t;

    // Controller -> datapath commands
    typedef struct packed {
        logic accept;   // request taken this cycle
        logic capture;  // memory read data is valid this cycle
    } ctrl_t;

    typedef struct packed {
        logic       spi_load_valid;
        logic [7:0] spi_load_byte;
        logic       push_accepted;
        logic       pop_valid;
        logic [7:0] pop_byte;
    } rsp_t;

endpackage

// ===== sv/ssfm_in_if.sv =====
// ----------------------------------------------------------------------------
// ssfm_in_if
// Request channel: valid/ready handshake with command and data byte.
// ----------------------------------------------------------------------------
interface ssfm_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] command;
    logic [7:0] data_byte;

    modport source (output valid, output command, output data_byte, input ready);
    modport sink   (input valid, input command, input data_byte, output ready);
endinterface

// ===== sv/ssfm_out_if.sv =====
// ----------------------------------------------------------------------------
// ssfm_out_if
// Result channel: valid/ready handshake with SPI load, push and pop status.
// ----------------------------------------------------------------------------
interface ssfm_out_if;
    logic       valid;
    logic       ready;
    logic       spi_load_valid;
    logic [7:0] spi_load_byte;
    logic       push_accepted;
    logic       pop_valid;
    logic [7:0] pop_byte;

    modport source (
        output valid, output spi_load_valid, output spi_load_byte,
        output push_accepted, output pop_valid, output pop_byte,
        input  ready
    );
    modport sink (
        input  valid, input spi_load_valid, input spi_load_byte,
        input  push_accepted, input pop_valid, input pop_byte,
        output ready
    );
endinterface

// ===== sv/ssfm_ram.sv =====
// ----------------------------------------------------------------------------
// ssfm_ram
// Generic RAM, one write port and one read port, registered read data.
// ----------------------------------------------------------------------------
module ssfm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== sv/ssfm_ctrl.sv =====
// ----------------------------------------------------------------------------
// ssfm_ctrl
// Request sequencer: take a request, wait for the memory read, hold result.
// ----------------------------------------------------------------------------
module ssfm_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    output ssfm_pkg::ctrl_t ctrl
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_READ = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready     = (state_reg == ST_IDLE);
    assign out_valid    = (state_reg == ST_DONE);
    assign ctrl.accept  = in_valid && in_ready;
    assign ctrl.capture = (state_reg == ST_READ);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // one request in flight: the read state follows the accept, then the done state with the result
    a_accept_then_capture: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.accept |=> ctrl.capture ##1 out_valid)
        else $error("capture/result did not follow accept");

    a_no_accept_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.capture || out_valid) |-> !in_ready)
        else $error("request accepted while one is in flight");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> out_valid)
        else $error("result dropped before it was taken");

endmodule

// ===== sv/ssfm_dp.sv =====
// ----------------------------------------------------------------------------
// ssfm_dp
// Ring pointers, protocol mode, transmit/receive memories, result register.
// ----------------------------------------------------------------------------
module ssfm_dp #(
    parameter int RING_DEPTH = ssfm_pkg::RING_DEPTH_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  ssfm_pkg::ctrl_t ctrl,
    input  logic [1:0]      command,
    input  logic [7:0]      data_byte,
    output ssfm_pkg::rsp_t  rsp
);

    localparam int              PTR_W = $clog2(RING_DEPTH);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(RING_DEPTH - 1);

    ssfm_pkg::mode_t mode_reg, mode_next;
    logic [PTR_W-1:0] tx_head_reg, tx_head_next;
    logic [PTR_W-1:0] tx_tail_reg, tx_tail_next;
    logic [PTR_W-1:0] rx_head_reg, rx_head_next;
    logic [PTR_W-1:0] rx_tail_reg, rx_tail_next;
    logic [RING_DEPTH-1:0] tx_vld_reg, tx_vld_next;  // slot written since reset
    logic tx_sel_reg, tx_sel_next;
    logic tx_hit_reg, tx_hit_next;
    logic rx_sel_reg, rx_sel_next;
    ssfm_pkg::rsp_t res_reg, res_next;

    logic [PTR_W-1:0] tx_head_inc, tx_tail_inc, rx_head_inc, rx_tail_inc;
    logic             tx_nonempty, rx_nonempty;

    logic       tx_wr_en, tx_rd_en, rx_wr_en, rx_rd_en;
    logic [7:0] tx_rd_data, rx_rd_data;

    assign tx_head_inc = (tx_head_reg == LAST) ? '0 : tx_head_reg + 1'b1;
    assign tx_tail_inc = (tx_tail_reg == LAST) ? '0 : tx_tail_reg + 1'b1;
    assign rx_head_inc = (rx_head_reg == LAST) ? '0 : rx_head_reg + 1'b1;
    assign rx_tail_inc = (rx_tail_reg == LAST) ? '0 : rx_tail_reg + 1'b1;
    assign tx_nonempty = (tx_head_reg != tx_tail_reg);
    assign rx_nonempty = (rx_head_reg != rx_tail_reg);

    always_comb
    begin
        mode_next    = mode_reg;
        tx_head_next = tx_head_reg;
        tx_tail_next = tx_tail_reg;
        rx_head_next = rx_head_reg;
        rx_tail_next = rx_tail_reg;
        tx_vld_next  = tx_vld_reg;
        tx_sel_next  = tx_sel_reg;
        tx_hit_next  = tx_hit_reg;
        rx_sel_next  = rx_sel_reg;
        res_next     = res_reg;
        tx_wr_en     = 1'b0;
        tx_rd_en     = 1'b0;
        rx_wr_en     = 1'b0;
        rx_rd_en     = 1'b0;

        if (ctrl.accept)
        begin
            res_next    = '0;
            tx_sel_next = 1'b0;
            rx_sel_next = 1'b0;
            case (command)
                ssfm_pkg::CMD_SPI:
                begin
                    case (mode_reg)
                        ssfm_pkg::MODE_SEND:
                        begin
                            // empty ring: head slot repeats, pointer stays
                            res_next.spi_load_valid = 1'b1;
                            tx_rd_en    = 1'b1;
                            tx_sel_next = 1'b1;
                            tx_hit_next = tx_vld_reg[tx_head_reg];
                            if (tx_nonempty)
                            begin
                                tx_head_next = tx_head_inc;
                            end
                            mode_next = ssfm_pkg::MODE_IDLE;
                        end
                        ssfm_pkg::MODE_RECV:
                        begin
                            // overflow: byte lands in the spare slot and is lost
                            rx_wr_en = 1'b1;
                            if (rx_tail_inc != rx_head_reg)
                            begin
                                rx_tail_next = rx_tail_inc;
                            end
                            mode_next = ssfm_pkg::MODE_IDLE;
                        end
                        default:
                        begin
                            if (data_byte == ssfm_pkg::SPI_POLL)
                            begin
                                res_next.spi_load_valid = 1'b1;
                                res_next.spi_load_byte  = {7'd0, tx_nonempty};
                            end
                            if (data_byte == ssfm_pkg::SPI_SEND)
                            begin
                                mode_next = ssfm_pkg::MODE_SEND;
                            end
                            else if (data_byte == ssfm_pkg::SPI_RECV)
                            begin
                                mode_next = ssfm_pkg::MODE_RECV;
                            end
                            else
                            begin
                                mode_next = ssfm_pkg::MODE_IDLE;
                            end
                        end
                    endcase
                end
                ssfm_pkg::CMD_PUSH:
                begin
                    // full ring still writes the spare slot
                    tx_wr_en = 1'b1;
                    tx_vld_next[tx_tail_reg] = 1'b1;
                    if (tx_tail_inc != tx_head_reg)
                    begin
                        tx_tail_next = tx_tail_inc;
                        res_next.push_accepted = 1'b1;
                    end
                end
                ssfm_pkg::CMD_POP:
                begin
                    if (rx_nonempty)
                    begin
                        res_next.pop_valid = 1'b1;
                        rx_rd_en     = 1'b1;
                        rx_sel_next  = 1'b1;
                        rx_head_next = rx_head_inc;
                    end
                end
                default:
                begin
                end
            endcase
        end

        if (ctrl.capture)
        begin
            if (tx_sel_reg)
            begin
                res_next.spi_load_byte = tx_hit_reg ? tx_rd_data : 8'd0;
            end
            if (rx_sel_reg)
            begin
                res_next.pop_byte = rx_rd_data;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= ssfm_pkg::MODE_IDLE;
            tx_head_reg <= '0;
            tx_tail_reg <= '0;
            rx_head_reg <= '0;
            rx_tail_reg <= '0;
            tx_vld_reg  <= '0;
            tx_sel_reg  <= 1'b0;
            tx_hit_reg  <= 1'b0;
            rx_sel_reg  <= 1'b0;
        end
        else
        begin
            mode_reg    <= mode_next;
            tx_head_reg <= tx_head_next;
            tx_tail_reg <= tx_tail_next;
            rx_head_reg <= rx_head_next;
            rx_tail_reg <= rx_tail_next;
            tx_vld_reg  <= tx_vld_next;
            tx_sel_reg  <= tx_sel_next;
            tx_hit_reg  <= tx_hit_next;
            rx_sel_reg  <= rx_sel_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    assign rsp = res_reg;

    ssfm_ram #(
        .WIDTH (8),
        .DEPTH (RING_DEPTH)
    ) u_tx_ram (
        .clk     (clk),
        .wr_en   (tx_wr_en),
        .wr_addr (tx_tail_reg),
        .wr_data (data_byte),
        .rd_en   (tx_rd_en),
        .rd_addr (tx_head_reg),
        .rd_data (tx_rd_data)
    );

    ssfm_ram #(
        .WIDTH (8),
        .DEPTH (RING_DEPTH)
    ) u_rx_ram (
        .clk     (clk),
        .wr_en   (rx_wr_en),
        .wr_addr (rx_tail_reg),
        .wr_data (data_byte),
        .rd_en   (rx_rd_en),
        .rd_addr (rx_head_reg),
        .rd_data (rx_rd_data)
    );

endmodule

// ===== sv/spi_slave_fifo_mailbox_top.sv =====
// Timing: a request is taken in the idle state; its result is valid in the done state after the read state.
// Only one request is in flight: the next is taken after the registered read of the ring
//   memories and after the held result has been taken.
// Reset (rst_n, async, active low): mode idle, all ring pointers zero, transmit slot
//   valid bits cleared so unwritten slots read as zero; no clearing pass is needed.
// ----------------------------------------------------------------------------
// spi_slave_fifo_mailbox_top
// SPI slave byte mailbox with a transmit ring and a receive ring.
// ----------------------------------------------------------------------------
//
// Request commands:
//   SPI byte  - while idle, the master byte picks the mode: status (load the
//               "transmit ring not empty" flag), send next, or receive next.
//               In send mode the transmit head is loaded and advanced unless
//               the ring is empty. In receive mode the byte goes into the
//               receive ring; on overflow it is dropped.
//   push      - local byte into the transmit ring; refused when full.
//   pop       - local read of the receive ring head.
// Each ring keeps one slot empty, so it holds RING_DEPTH-1 bytes.
//
// Structure: ssfm_ctrl sequences each request (idle -> read -> done),
// ssfm_dp holds the pointers, mode, the two ring memories and the result
// register that parts the request side from the result side.
module spi_slave_fifo_mailbox_top #(
    parameter int RING_DEPTH = ssfm_pkg::RING_DEPTH_DEF
) (
    input logic   clk,
    input logic   rst_n,
    ssfm_in_if.sink    req,
    ssfm_out_if.source rsp
);

    ssfm_pkg::ctrl_t ctrl;
    ssfm_pkg::rsp_t  res;

    ssfm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_valid (rsp.valid),
        .out_ready (rsp.ready),
        .ctrl      (ctrl)
    );

    ssfm_dp #(
        .RING_DEPTH (RING_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (ctrl),
        .command   (req.command),
        .data_byte (req.data_byte),
        .rsp       (res)
    );

    // result fields straight from the result register
    assign rsp.spi_load_valid = res.spi_load_valid;
    assign rsp.spi_load_byte  = res.spi_load_byte;
    assign rsp.push_accepted  = res.push_accepted;
    assign rsp.pop_valid      = res.pop_valid;
    assign rsp.pop_byte       = res.pop_byte;

endmodule

// ===== test/ssfm_chk.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ssfm_chk
// Watches both channels of the mailbox, tracks the two rings and the SPI
// mode, and compares every result against the predicted one in order.
// ----------------------------------------------------------------------------
module ssfm_chk (
    input  logic clk,
    input  logic rst_n,
    ssfm_in_if   req,
    ssfm_out_if  rsp,
    output int   errors,
    output int   pending,
    output int   checked,
    output int   full_pushes,
    output int   rx_drops,
    output int   stale_sends,
    output int   dry_pops
);
    import ssfm_pkg::*;

    localparam int DEPTH = RING_DEPTH_DEF;
    localparam int PW    = $clog2(DEPTH);

    mode_t           mode;
    logic [7:0]      tx_mem [DEPTH];
    logic [7:0]      rx_mem [DEPTH];
    logic [PW-1:0]   tx_head, tx_tail, rx_head, rx_tail;
    rsp_t            rsp_due [$];

    function automatic logic [PW-1:0] bump(logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic string rsp_text(rsp_t r);
        return $sformatf("load=%0b/%02h push_ok=%0b pop=%0b/%02h", r.spi_load_valid,
                         r.spi_load_byte, r.push_accepted, r.pop_valid, r.pop_byte);
    endfunction

    // One request against the ring state; returns the result it must produce.
    function automatic rsp_t advance_rings(logic [1:0] cmd, logic [7:0] b);
        rsp_t          r;
        logic [PW-1:0] nxt;
        r = '0;
        case (cmd)
            CMD_SPI:
            begin
                case (mode)
                    MODE_SEND:
                    begin
                        r.spi_load_valid = 1'b1;
                        r.spi_load_byte  = tx_mem[tx_head];
                        if (tx_head != tx_tail)
                            tx_head = bump(tx_head);
                        else
                            stale_sends++;      // empty ring: same byte again
                        mode = MODE_IDLE;
                    end
                    MODE_RECV:
                    begin
                        rx_mem[rx_tail] = b;    // spare slot written even on overflow
                        nxt = bump(rx_tail);
                        if (nxt != rx_head)
                            rx_tail = nxt;
                        else
                            rx_drops++;
                        mode = MODE_IDLE;
                    end
                    default:
                    begin
                        if (b == SPI_POLL)
                        begin
                            r.spi_load_valid = 1'b1;
                            r.spi_load_byte  = {7'd0, tx_head != tx_tail};
                        end
                        if (b == SPI_SEND)
                            mode = MODE_SEND;
                        else if (b == SPI_RECV)
                            mode = MODE_RECV;
                        else
                            mode = MODE_IDLE;
                    end
                endcase
            end
            CMD_PUSH:
            begin
                tx_mem[tx_tail] = b;
                nxt = bump(tx_tail);
                if (nxt != tx_head)
                begin
                    tx_tail = nxt;
                    r.push_accepted = 1'b1;
                end
                else
                    full_pushes++;
            end
            CMD_POP:
            begin
                if (rx_head != rx_tail)
                begin
                    r.pop_valid = 1'b1;
                    r.pop_byte  = rx_mem[rx_head];
                    rx_head = bump(rx_head);
                end
                else
                    dry_pops++;
            end
            default: ;  // reserved command: all-zero result
        endcase
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want, got;
        if (!rst_n)
        begin
            mode    = MODE_IDLE;
            tx_head = '0;
            tx_tail = '0;
            rx_head = '0;
            rx_tail = '0;
            for (int i = 0; i < DEPTH; i++)
            begin
                tx_mem[i] = '0;
                rx_mem[i] = '0;
            end
            rsp_due.delete();
            pending = 0;
        end
        else
        begin
            // results first: a request taken at this edge cannot answer here
            if (rsp.valid && rsp.ready)
            begin
                got.spi_load_valid = rsp.spi_load_valid;
                got.spi_load_byte  = rsp.spi_load_byte;
                got.push_accepted  = rsp.push_accepted;
                got.pop_valid      = rsp.pop_valid;
                got.pop_byte       = rsp.pop_byte;
                checked++;
                if (rsp_due.size() == 0)
                begin
                    errors++;
                    if (errors <= 10)
                        $display("%0t chk: unexpected result %s", $realtime, rsp_text(got));
                end
                else
                begin
                    want = rsp_due.pop_front();
                    if (got !== want)
                    begin
                        errors++;
                        if (errors <= 10)
                            $display("%0t chk: result %0d expected %s got %s", $realtime,
                                     checked, rsp_text(want), rsp_text(got));
                    end
                end
            end
            if (req.valid && req.ready)
                rsp_due.push_back(advance_rings(req.command, req.data_byte));
            pending = rsp_due.size();
        end
    end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Mailbox testbench: directed corner requests, then randomized phases that
// fill and drain both rings, with bursty requests and a stalling receiver.
// ----------------------------------------------------------------------------
module tb;
    import ssfm_pkg::*;

    localparam logic [1:0] CMD_RSVD   = 2'd3;  // no operation, all-zero result
    localparam int         N_RANDOM   = 1650;
    localparam int         IDLE_LIMIT = 4000;  // cycles with no handshake at all

    typedef enum int {PH_FILL, PH_DRAIN, PH_MIX} phase_t;

    logic clk;
    logic rst_n;

    ssfm_in_if  req_if ();
    ssfm_out_if rsp_if ();

    int errors, pending, checked;
    int full_pushes, rx_drops, stale_sends, dry_pops;

    int sent;        // requests accepted so far
    int burst_left;  // requests left in the current sender burst

    spi_slave_fifo_mailbox_top u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    ssfm_chk u_chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req_if),
        .rsp         (rsp_if),
        .errors      (errors),
        .pending     (pending),
        .checked     (checked),
        .full_pushes (full_pushes),
        .rx_drops    (rx_drops),
        .stale_sends (stale_sends),
        .dry_pops    (dry_pops)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Present one request at the falling edge and hold it until taken.
    // Bursts of random length; between bursts valid drops for a random gap.
    task automatic issue(input logic [1:0] cmd, input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 4);
            if (gap > 0)
            begin
                req_if.valid = 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
        end
        req_if.valid     = 1'b1;
        req_if.command   = cmd;
        req_if.data_byte = b;
        @(posedge clk);
        while (!req_if.ready)
            @(posedge clk);
        @(negedge clk);
        burst_left--;
        sent++;
    endtask

    // Sender stops until every outstanding result has drained.
    task automatic hold_off();
        req_if.valid = 1'b0;
        burst_left   = 0;
        while (pending != 0)
            @(negedge clk);
    endtask

    // Receiver stall pattern: spans of always-ready, coin-flip, periodic
    // and long-stall behavior, each span of random length.
    initial
    begin
        int span, style, tick, period, stall_left;
        rsp_if.ready = 1'b0;
        span = 0;
        tick = 0;
        period = 2;
        stall_left = 0;
        style = 0;
        forever
        begin
            @(negedge clk);
            if (span == 0)
            begin
                style  = $urandom_range(0, 3);
                span   = $urandom_range(30, 300);
                period = $urandom_range(2, 5);
            end
            span--;
            tick++;
            case (style)
                0: rsp_if.ready = 1'b1;
                1: rsp_if.ready = 1'($urandom_range(0, 1));
                2: rsp_if.ready = (tick % period) == 0;
                default:
                begin
                    if (stall_left > 0)
                    begin
                        stall_left--;
                        rsp_if.ready = 1'b0;
                    end
                    else
                    begin
                        if ($urandom_range(0, 19) == 0)
                            stall_left = $urandom_range(5, 30);
                        rsp_if.ready = 1'b1;
                    end
                end
            endcase
        end
    end

    // Watchdog: ends the run if neither channel moves for too long.
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("tb: timeout, no handshake for %0d cycles, %0d results outstanding",
                 IDLE_LIMIT, pending);
        $display("tb: FAIL");
        $finish;
    end

    initial
    begin
        phase_t ph;
        int     stop_at, r, w_push, w_recv, w_stat, w_send, w_pop;

        req_if.valid     = 1'b0;
        req_if.command   = CMD_SPI;
        req_if.data_byte = 8'h00;
        rst_n      = 1'b0;
        sent       = 0;
        burst_left = 0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // ---- directed corners ----
        issue(CMD_SPI, SPI_POLL);       // status with empty transmit ring -> 0
        issue(CMD_SPI, SPI_SEND);       // send from an empty ring: reset byte,
        issue(CMD_SPI, 8'hFF);          //   head stays put
        issue(CMD_POP, 8'hFF);          // pop from empty receive ring
        issue(CMD_RSVD, 8'hFF);         // reserved command is ignored
        issue(CMD_SPI, 8'hFF);          // unknown idle bytes load nothing
        issue(CMD_SPI, 8'h03);
        issue(CMD_PUSH, 8'hFF);
        issue(CMD_PUSH, 8'h00);
        issue(CMD_PUSH, 8'hA5);
        issue(CMD_SPI, SPI_POLL);       // status now 1
        issue(CMD_SPI, SPI_SEND);       // head byte 0xFF goes out
        issue(CMD_SPI, 8'h5A);
        issue(CMD_SPI, SPI_RECV);       // two bytes into receive ring
        issue(CMD_SPI, 8'hFF);
        issue(CMD_SPI, SPI_RECV);
        issue(CMD_SPI, 8'h00);
        issue(CMD_POP, 8'h00);
        issue(CMD_POP, 8'h00);
        issue(CMD_POP, 8'h00);          // empty again
        hold_off();

        // ---- random phases ----
        // Fill phases push hard and receive hard to hit the full transmit
        // ring and the receive overflow; drain phases send and pop to empty
        // both rings; mixed phases sit in between. The remainder of each
        // weight table is noise: stray bytes, reserved commands and mode
        // bytes interrupted by local traffic.
        stop_at = sent + N_RANDOM;
        while (sent < stop_at)
        begin
            ph = phase_t'($urandom_range(0, 2));
            case (ph)
                PH_FILL:
                begin
                    w_push = 35; w_recv = 30; w_stat = 5; w_send = 5; w_pop = 5;
                end
                PH_DRAIN:
                begin
                    w_push = 5; w_recv = 5; w_stat = 10; w_send = 35; w_pop = 30;
                end
                default:
                begin
                    w_push = 20; w_recv = 20; w_stat = 10; w_send = 20; w_pop = 20;
                end
            endcase
            r = sent + $urandom_range(80, 200);
            while (sent < r && sent < stop_at)
            begin
                int pick;
                pick = $urandom_range(0, 99);
                if (pick < w_push)
                    issue(CMD_PUSH, 8'($urandom));
                else if (pick < w_push + w_recv)
                begin
                    issue(CMD_SPI, SPI_RECV);
                    issue(CMD_SPI, 8'($urandom));
                end
                else if (pick < w_push + w_recv + w_stat)
                    issue(CMD_SPI, SPI_POLL);
                else if (pick < w_push + w_recv + w_stat + w_send)
                begin
                    issue(CMD_SPI, SPI_SEND);
                    issue(CMD_SPI, 8'($urandom));
                end
                else if (pick < w_push + w_recv + w_stat + w_send + w_pop)
                    issue(CMD_POP, 8'($urandom));
                else
                begin
                    case ($urandom_range(0, 3))
                        0: issue(CMD_SPI, 8'($urandom));
                        1: issue(CMD_RSVD, 8'($urandom));
                        2:
                        begin
                            // mode byte, local traffic in between, then the data byte
                            issue(CMD_SPI, $urandom_range(0, 1) ? SPI_SEND : SPI_RECV);
                            issue($urandom_range(0, 1) ? CMD_PUSH : CMD_POP, 8'($urandom));
                            issue(CMD_SPI, 8'($urandom));
                        end
                        default: issue(2'($urandom_range(0, 3)), 8'($urandom));
                    endcase
                end
            end
            if ($urandom_range(0, 2) == 0)
                hold_off();
        end

        // ---- drain and verdict ----
        hold_off();
        repeat (8) @(negedge clk);
        $display("tb: %0d requests, %0d results checked, %0d mismatches", sent, checked,
                 errors);
        $display("tb: corners hit: %0d refused pushes, %0d receive overflows, %0d sends %s",
                 full_pushes, rx_drops, stale_sends,
                 $sformatf("from empty ring, %0d pops from empty ring", dry_pops));
        if (errors == 0 && pending == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/ssfm_pkg.sv
sv/ssfm_in_if.sv
sv/ssfm_out_if.sv
sv/ssfm_ram.sv
sv/ssfm_ctrl.sv
sv/ssfm_dp.sv
sv/spi_slave_fifo_mailbox_top.sv
test/ssfm_chk.sv
test/tb.sv
